>>> src/triangle_plane_slicer_assert.svh
// assertion macros shared by the slicer rtl
`ifndef TRIANGLE_PLANE_SLICER_ASSERT_SVH
`define TRIANGLE_PLANE_SLICER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slicer check failed");

// next-cycle implication, checked outside reset
`define TPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slicer check failed");

// next-cycle implication, also checked across reset
`define TPS_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("slicer reset check failed");

`endif

>>> src/tri_slc_pkg.sv
package tri_slc_pkg;

    localparam int COORD_W   = 32;
    localparam int THICK_W   = 31;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int REM_W     = PROD_W + 1;
    localparam int QUO_W     = COORD_W + 1;
    localparam int NUM_LANES = 4;
    localparam int IN_W      = 9 * COORD_W;
    localparam int OUT_W     = NUM_LANES * COORD_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THICK  = 1'b1;

    // where an endpoint comes from: an edge to interpolate or a vertex taken as is
    typedef enum logic [2:0] {
        SRC_E01,
        SRC_E12,
        SRC_E02,
        SRC_V0,
        SRC_V1,
        SRC_V2
    } t_src;

endpackage

>>> src/triangle_plane_slicer.sv
// triangle_plane_slicer
// Slices one triangle per transfer with the plane z = plane_height.
// Slave channel: i_s_tdata carries v1_x..v3_z, 32 bits each, v1_x lowest.
// Master channel: o_m_tdata carries seg_x1, seg_y1, seg_x2, seg_y2, seg_x1 lowest.
// A triangle that misses the plane gives no master transfer at all.
// Config port: i_cfg_wen writes i_cfg_data to register i_cfg_idx
// (0 plane_height, 1 layer_thickness); write only while the block is empty.
// Throughput: one triangle per cycle, with no bubbles, while the receiver does not stall.
// The depth from the slave transfer to o_m_tvalid is set by
// a restoring divider, one quotient bit per stage over 33 stages, four lanes wide.
// Reset clears all valid bits and both registers; the pipeline comes up empty.
// When the receiver stalls, the whole pipeline holds and o_s_tready drops;
// the output register keeps its segment until it is taken.
module triangle_plane_slicer
    import tri_slc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z
    input  logic [IN_W-1:0]      i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // seg_x1, seg_y1, seg_x2, seg_y2
    output logic [OUT_W-1:0]     o_m_tdata,
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_W-1:0]   i_cfg_data
);

    localparam int DIV_N = QUO_W;

    logic w_en;

    logic signed [COORD_W-1:0] r_h;
    logic        [THICK_W-1:0] r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= '0;
            r_t <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                REG_HEIGHT: r_h <= i_cfg_data;
                REG_THICK:  r_t <= i_cfg_data[THICK_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: classify vertices against the plane
    logic                      r1_vld;
    logic signed [COORD_W-1:0] r1_x [3];
    logic signed [COORD_W-1:0] r1_y [3];
    logic signed [COORD_W-1:0] r1_z [3];
    logic [2:0]                r1_on, r1_lt, r1_gt;
    logic                      r1_rej;

    logic signed [COORD_W-1:0] n_x [3];
    logic signed [COORD_W-1:0] n_y [3];
    logic signed [COORD_W-1:0] n_z [3];
    logic [2:0]                n_on, n_lt, n_gt, n_above;
    logic signed [DIFF_W-1:0]  w_top;

    always_comb begin
        w_top = $signed({r_h[COORD_W-1], r_h}) + $signed({2'b00, r_t});
        for (int i = 0; i < 3; i++) begin
            n_x[i]     = i_s_tdata[(3*i)*COORD_W +: COORD_W];
            n_y[i]     = i_s_tdata[(3*i+1)*COORD_W +: COORD_W];
            n_z[i]     = i_s_tdata[(3*i+2)*COORD_W +: COORD_W];
            n_on[i]    = (n_z[i] == r_h);
            n_lt[i]    = (n_z[i] < r_h);
            n_gt[i]    = (n_z[i] > r_h);
            n_above[i] = ($signed({n_z[i][COORD_W-1], n_z[i]}) > w_top);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x   <= n_x;
            r1_y   <= n_y;
            r1_z   <= n_z;
            r1_on  <= n_on;
            r1_lt  <= n_lt;
            r1_gt  <= n_gt;
            r1_rej <= (&n_lt) | (&n_above);
        end
    end

    // stage 2: choose endpoint sources, form differences per lane
    logic                      r2_vld, r2_emit;
    logic signed [COORD_W-1:0] r2_base [NUM_LANES];
    logic signed [DIFF_W-1:0]  r2_num  [NUM_LANES];
    logic signed [DIFF_W-1:0]  r2_dv   [NUM_LANES];
    logic signed [DIFF_W-1:0]  r2_dz   [NUM_LANES];

    t_src                      w_src [2];
    logic [1:0]                w_have;
    logic                      w_pair, w_emit;
    logic                      w_c01, w_c12, w_c02;
    logic [1:0]                w_ia, w_ib;
    logic                      w_direct;
    logic signed [COORD_W-1:0] w_ca, w_cb;
    logic signed [DIFF_W-1:0]  n2_num [NUM_LANES];
    logic signed [DIFF_W-1:0]  n2_dv  [NUM_LANES];
    logic signed [DIFF_W-1:0]  n2_dz  [NUM_LANES];
    logic signed [COORD_W-1:0] n2_base [NUM_LANES];

    always_comb begin
        w_c01  = (r1_gt[0] & r1_lt[1]) | (r1_lt[0] & r1_gt[1]);
        w_c12  = (r1_gt[1] & r1_lt[2]) | (r1_lt[1] & r1_gt[2]);
        w_c02  = (r1_gt[0] & r1_lt[2]) | (r1_lt[0] & r1_gt[2]);
        w_pair = 1'b1;
        w_have = 2'b00;
        w_src[0] = SRC_V0;
        w_src[1] = SRC_V1;
        if (r1_on[0] && r1_on[1]) begin
            w_src[0] = SRC_V0;
            w_src[1] = SRC_V1;
        end else if (r1_on[0] && r1_on[2]) begin
            w_src[0] = SRC_V0;
            w_src[1] = SRC_V2;
        end else if (r1_on[1] && r1_on[2]) begin
            w_src[0] = SRC_V1;
            w_src[1] = SRC_V2;
        end else begin
            w_pair = 1'b0;
            if (w_c01) begin
                w_src[0]  = SRC_E01;
                w_have[0] = 1'b1;
                if (w_c12) begin
                    w_src[1]  = SRC_E12;
                    w_have[1] = 1'b1;
                end else if (w_c02) begin
                    w_src[1]  = SRC_E02;
                    w_have[1] = 1'b1;
                end
            end else begin
                if (w_c12) begin
                    w_src[0]  = SRC_E12;
                    w_have[0] = 1'b1;
                end
                if (w_c02) begin
                    w_src[1]  = SRC_E02;
                    w_have[1] = 1'b1;
                end
            end
            // a single vertex on the plane fills the first empty slot
            if (r1_on != 3'b000) begin
                if (!w_have[0]) begin
                    w_src[0]  = r1_on[2] ? SRC_V2 : (r1_on[1] ? SRC_V1 : SRC_V0);
                    w_have[0] = 1'b1;
                end else if (!w_have[1]) begin
                    w_src[1]  = r1_on[2] ? SRC_V2 : (r1_on[1] ? SRC_V1 : SRC_V0);
                    w_have[1] = 1'b1;
                end
            end
        end
        w_emit = !r1_rej && (w_pair || (&w_have));

        w_ia = 2'd0;
        w_ib = 2'd0;
        w_direct = 1'b1;
        w_ca = '0;
        w_cb = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            case (w_src[l/2])
                SRC_E01: begin w_ia = 2'd0; w_ib = 2'd1; w_direct = 1'b0; end
                SRC_E12: begin w_ia = 2'd1; w_ib = 2'd2; w_direct = 1'b0; end
                SRC_E02: begin w_ia = 2'd0; w_ib = 2'd2; w_direct = 1'b0; end
                SRC_V0:  begin w_ia = 2'd0; w_ib = 2'd0; w_direct = 1'b1; end
                SRC_V1:  begin w_ia = 2'd1; w_ib = 2'd1; w_direct = 1'b1; end
                SRC_V2:  begin w_ia = 2'd2; w_ib = 2'd2; w_direct = 1'b1; end
                default: begin w_ia = 2'd0; w_ib = 2'd0; w_direct = 1'b1; end
            endcase
            w_ca = (l % 2 == 1) ? r1_y[w_ia] : r1_x[w_ia];
            w_cb = (l % 2 == 1) ? r1_y[w_ib] : r1_x[w_ib];
            n2_base[l] = w_ca;
            if (w_direct) begin
                n2_num[l] = '0;
                n2_dv[l]  = '0;
                n2_dz[l]  = DIFF_W'(1);
            end else begin
                n2_num[l] = $signed({r_h[COORD_W-1], r_h})
                          - $signed({r1_z[w_ia][COORD_W-1], r1_z[w_ia]});
                n2_dv[l]  = $signed({w_cb[COORD_W-1], w_cb})
                          - $signed({w_ca[COORD_W-1], w_ca});
                n2_dz[l]  = $signed({r1_z[w_ib][COORD_W-1], r1_z[w_ib]})
                          - $signed({r1_z[w_ia][COORD_W-1], r1_z[w_ia]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_emit <= w_emit;
            r2_base <= n2_base;
            r2_num  <= n2_num;
            r2_dv   <= n2_dv;
            r2_dz   <= n2_dz;
        end
    end

    // stage 3: magnitudes and result sign
    logic                      r3_vld, r3_emit;
    logic signed [COORD_W-1:0] r3_base [NUM_LANES];
    logic        [DIFF_W-1:0]  r3_un   [NUM_LANES];
    logic        [DIFF_W-1:0]  r3_ud   [NUM_LANES];
    logic        [DIFF_W-1:0]  r3_uz   [NUM_LANES];
    logic                      r3_neg  [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_emit <= r2_emit;
            r3_base <= r2_base;
            for (int l = 0; l < NUM_LANES; l++) begin
                r3_un[l]  <= r2_num[l][DIFF_W-1] ? DIFF_W'(-r2_num[l]) : DIFF_W'(r2_num[l]);
                r3_ud[l]  <= r2_dv[l][DIFF_W-1]  ? DIFF_W'(-r2_dv[l])  : DIFF_W'(r2_dv[l]);
                r3_uz[l]  <= r2_dz[l][DIFF_W-1]  ? DIFF_W'(-r2_dz[l])  : DIFF_W'(r2_dz[l]);
                r3_neg[l] <= r2_num[l][DIFF_W-1] ^ r2_dv[l][DIFF_W-1] ^ r2_dz[l][DIFF_W-1];
            end
        end
    end

    // stage 4: product
    logic                      r4_vld, r4_emit;
    logic signed [COORD_W-1:0] r4_base [NUM_LANES];
    logic        [PROD_W-1:0]  r4_p    [NUM_LANES];
    logic        [DIFF_W-1:0]  r4_uz   [NUM_LANES];
    logic                      r4_neg  [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_emit <= r3_emit;
            r4_base <= r3_base;
            r4_uz   <= r3_uz;
            r4_neg  <= r3_neg;
            for (int l = 0; l < NUM_LANES; l++) begin
                r4_p[l] <= PROD_W'(r3_un[l]) * PROD_W'(r3_ud[l]);
            end
        end
    end

    // divider: entry 0 takes the rounded dividend, each later entry one quotient bit
    logic                      r_dvld  [DIV_N+1];
    logic                      r_demit [DIV_N+1];
    logic signed [COORD_W-1:0] r_dbase [DIV_N+1][NUM_LANES];
    logic        [REM_W-1:0]   r_rem   [DIV_N+1][NUM_LANES];
    logic        [DIFF_W-1:0]  r_uz    [DIV_N+1][NUM_LANES];
    logic        [QUO_W-1:0]   r_q     [DIV_N+1][NUM_LANES];
    logic                      r_dneg  [DIV_N+1][NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld[0] <= 1'b0;
        end else if (w_en) begin
            r_dvld[0] <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_demit[0] <= r4_emit;
            r_dbase[0] <= r4_base;
            r_uz[0]    <= r4_uz;
            r_dneg[0]  <= r4_neg;
            for (int l = 0; l < NUM_LANES; l++) begin
                r_rem[0][l] <= REM_W'(r4_p[l]) + REM_W'(r4_uz[l] >> 1);
                r_q[0][l]   <= '0;
            end
        end
    end

    for (genvar k = 1; k <= DIV_N; k++) begin : g_div
        localparam int BIT = DIV_N - k;
        logic [REM_W-1:0] w_sh [NUM_LANES];
        logic             w_ge [NUM_LANES];

        always_comb begin
            for (int l = 0; l < NUM_LANES; l++) begin
                w_sh[l] = REM_W'(r_uz[k-1][l]) << BIT;
                w_ge[l] = (r_rem[k-1][l] >= w_sh[l]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvld[k] <= 1'b0;
            end else if (w_en) begin
                r_dvld[k] <= r_dvld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_demit[k] <= r_demit[k-1];
                r_dbase[k] <= r_dbase[k-1];
                r_uz[k]    <= r_uz[k-1];
                r_dneg[k]  <= r_dneg[k-1];
                for (int l = 0; l < NUM_LANES; l++) begin
                    r_rem[k][l] <= w_ge[l] ? (r_rem[k-1][l] - w_sh[l]) : r_rem[k-1][l];
                    r_q[k][l]   <= r_q[k-1][l] | (QUO_W'(w_ge[l]) << BIT);
                end
            end
        end
    end

    // output: apply sign, saturate, hold until taken
    logic                      r_out_vld;
    logic [OUT_W-1:0]          r_out_data;
    logic signed [DIFF_W:0]    w_sum [NUM_LANES];
    logic [OUT_W-1:0]          n_out_data;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            w_sum[l] = r_dneg[DIV_N][l]
                ? $signed({{2{r_dbase[DIV_N][l][COORD_W-1]}}, r_dbase[DIV_N][l]})
                  - $signed({1'b0, r_q[DIV_N][l]})
                : $signed({{2{r_dbase[DIV_N][l][COORD_W-1]}}, r_dbase[DIV_N][l]})
                  + $signed({1'b0, r_q[DIV_N][l]});
            if (w_sum[l] > $signed({3'b000, {(COORD_W-1){1'b1}}})) begin
                n_out_data[l*COORD_W +: COORD_W] = {1'b0, {(COORD_W-1){1'b1}}};
            end else if (w_sum[l] < $signed({3'b111, {(COORD_W-1){1'b0}}})) begin
                n_out_data[l*COORD_W +: COORD_W] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                n_out_data[l*COORD_W +: COORD_W] = w_sum[l][COORD_W-1:0];
            end
        end
    end

    assign w_en = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dvld[DIV_N] && r_demit[DIV_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_s_tready = w_en;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    `include "triangle_plane_slicer_assert.svh"

    `TPS_ASSERT_NEXT(a_stall_holds, !w_en, $stable(r_dvld[DIV_N]) && $stable(r2_vld))
    `TPS_ASSERT_NOW(a_rem_below, r_dvld[DIV_N], r_rem[DIV_N][0] < REM_W'(r_uz[DIV_N][0]))
    `TPS_ASSERT_NOW(a_dz_nonzero, r2_vld && r2_emit, r2_dz[0] != '0 && r2_dz[3] != '0)
    `TPS_ASSERT_RST(a_reset_empty, !i_rst_n, !o_m_tvalid && !r_dvld[0])

endmodule
